// ===== rtl/core/vvtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vvtp_pkg
// Shared widths, register indexes and coefficient types of the vertex view
// transform and projection pipeline.
// ----------------------------------------------------------------------------
package vvtp_pkg;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_AZIMUTH   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ELEVATION = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PIVOT_X   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PIVOT_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PIVOT_Z   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SCALE     = 3'd5;
    localparam logic [CFG_AW-1:0] REG_OFF_HORIZ = 3'd6;
    localparam logic [CFG_AW-1:0] REG_OFF_VERT  = 3'd7;

    // field widths
    localparam int ANGLE_W = 9;
    localparam int COORD_W = 24;
    localparam int SCALE_W = 32;
    localparam int OFF_W   = 32;
    localparam int PIX_W   = 16;
    localparam int DEPTH_W = 32;

    // datapath widths
    localparam int TRIG_W  = 18;                 // Q1.16 signed, +-1.0 inclusive
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = TRIG_W + DELTA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int EYE_W   = 28;                 // eye coordinates, Q.8

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // viewer distance in Q.8
    localparam int VIEW_DISTANCE = 3000;
    localparam logic signed [EYE_W-1:0] VIEW_OFS = EYE_W'(VIEW_DISTANCE * 256);

    // series constants, Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        t_trig v11;
        t_trig v21;
        t_trig v12;
        t_trig v22;
        t_trig v13;
        t_trig v23;
        t_trig v32;
        t_trig v33;
    } t_coef;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_view_transform_project.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_view_transform_project
// Rotates each vertex about a pivot, adds viewer distance, and projects it
// to a saturated 16-bit screen pixel with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake                       Payload
// s_axis     in   i_s_axis_tvalid/o_s_axis_tready tdata x,y,z; tlast batch_end
// m_axis     out  o_m_axis_tvalid/i_m_axis_tready tdata px,py,depth; tuser vis;
//                                                 tlast batch_done
// cfg        in   i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
// One item per cycle sustained while the skid entry is empty.
// The datapath is dominated by the 59-stage one-bit-per-stage divider.
// i_rst_n is synchronous; it clears valid bits and the configuration registers.
// A stalled output fills a two-entry output/skid pair; the whole pipeline
// then holds in place until the skid entry drains.
// ----------------------------------------------------------------------------
module vertex_view_transform_project #(
    parameter int ANGLE_STEPS = 360
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [vvtp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [vvtp_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [71:0]                 i_s_axis_tdata,  // model_x, model_y, model_z
    input  wire logic                        i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [63:0]                      o_m_axis_tdata,  // pixel_x, pixel_y, eye_depth
    output logic                             o_m_axis_tlast,
    output logic                             o_m_axis_tuser   // visible
);

    localparam int CW      = vvtp_pkg::COORD_W;
    localparam int TW      = vvtp_pkg::TRIG_W;
    localparam int EW      = vvtp_pkg::EYE_W;
    localparam int ZW      = EW - 1;                         // divisor, positive depth
    localparam int MW      = EW + vvtp_pkg::SCALE_W + 1;     // e * scale
    localparam int NW      = MW - 2;                         // numerator magnitude
    localparam int FW      = NW + 2;                         // quotient plus offset
    localparam int ROM_D   = 2 ** vvtp_pkg::ANGLE_W;

    typedef logic [ROM_D-1:0][2*TW-1:0] t_rom;

    localparam logic signed [vvtp_pkg::SUM_W-1:0] RND_HALF = 45'sd32768;
    localparam logic signed [FW-1:0] F_BIAS = 61'sd65535;
    localparam logic signed [FW-1:0] F_ZERO = 61'sd0;
    localparam logic signed [FW-1:0] PIX_HI = 61'sd32767;
    localparam logic signed [FW-1:0] PIX_LO = -61'sd32768;

    // shift-and-subtract quotient, only used while the table is built
    function automatic longint unsigned cdiv(input longint unsigned a,
                                             input longint unsigned d);
        longint unsigned q, rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], a[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin/cos per raw register code, angle taken modulo ANGLE_STEPS
    function automatic t_rom build_rom();
        t_rom              rom;
        longint unsigned   k, t, r, x, x2, st, ct;
        longint            ssum, csum, s16, c16, sn, cs;
        logic [1:0]        quad;
        rom = '0;
        for (int i = 0; i < ROM_D; i++) begin
            k    = 64'(i);
            k    = k - cdiv(k, 64'(ANGLE_STEPS)) * 64'(ANGLE_STEPS);
            t    = cdiv(k << 32, 64'(ANGLE_STEPS));
            quad = t[31:30];
            r    = t & (vvtp_pkg::ONE_Q30 - 64'd1);
            x    = (r * vvtp_pkg::HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            st   = x;
            ct   = vvtp_pkg::ONE_Q30;
            ssum = longint'(x);
            csum = longint'(vvtp_pkg::ONE_Q30);
            for (int n = 1; n <= 8; n++) begin
                st = cdiv((st * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                ct = cdiv((ct * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
                if (n % 2 == 1) begin
                    ssum = ssum - longint'(st);
                    csum = csum - longint'(ct);
                end else begin
                    ssum = ssum + longint'(st);
                    csum = csum + longint'(ct);
                end
            end
            if (ssum < 0) ssum = 0;
            if (ssum > longint'(vvtp_pkg::ONE_Q30)) ssum = longint'(vvtp_pkg::ONE_Q30);
            if (csum < 0) csum = 0;
            if (csum > longint'(vvtp_pkg::ONE_Q30)) csum = longint'(vvtp_pkg::ONE_Q30);
            s16 = (ssum + 8192) >>> 14;
            c16 = (csum + 8192) >>> 14;
            unique case (quad)
                2'd0: begin sn = s16;  cs = c16;  end
                2'd1: begin sn = c16;  cs = -s16; end
                2'd2: begin sn = -s16; cs = -c16; end
                default: begin sn = -c16; cs = s16; end
            endcase
            rom[i] = {TW'(sn), TW'(cs)};
        end
        return rom;
    endfunction

    localparam t_rom TRIG_ROM = build_rom();

    // round-half-up product of two Q1.16 values
    function automatic vvtp_pkg::t_trig rnd_mul(input vvtp_pkg::t_trig a,
                                                input vvtp_pkg::t_trig b);
        logic signed [2*TW-1:0] p;
        p = a * b;
        p = p + 36'sd32768;
        return TW'(p >>> 16);
    endfunction

    // truncate toward zero by 2^16, saturate to 16 bits
    function automatic logic signed [vvtp_pkg::PIX_W-1:0] to_pixel(
        input logic signed [FW-1:0] s);
        logic signed [FW-1:0] a;
        a = s + (s[FW-1] ? F_BIAS : F_ZERO);
        a = a >>> 16;
        if (a > PIX_HI) a = PIX_HI;
        if (a < PIX_LO) a = PIX_LO;
        return vvtp_pkg::PIX_W'(a);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [vvtp_pkg::ANGLE_W-1:0]        r_az, r_el;
    logic signed [CW-1:0]                r_piv_x, r_piv_y, r_piv_z;
    logic [vvtp_pkg::SCALE_W-1:0]        r_scale;
    logic signed [vvtp_pkg::OFF_W-1:0]   r_off_h, r_off_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az    <= '0;
            r_el    <= '0;
            r_piv_x <= '0;
            r_piv_y <= '0;
            r_piv_z <= '0;
            r_scale <= vvtp_pkg::SCALE_RESET;
            r_off_h <= '0;
            r_off_v <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vvtp_pkg::REG_AZIMUTH:   r_az    <= i_cfg_wdata[vvtp_pkg::ANGLE_W-1:0];
                vvtp_pkg::REG_ELEVATION: r_el    <= i_cfg_wdata[vvtp_pkg::ANGLE_W-1:0];
                vvtp_pkg::REG_PIVOT_X:   r_piv_x <= i_cfg_wdata[CW-1:0];
                vvtp_pkg::REG_PIVOT_Y:   r_piv_y <= i_cfg_wdata[CW-1:0];
                vvtp_pkg::REG_PIVOT_Z:   r_piv_z <= i_cfg_wdata[CW-1:0];
                vvtp_pkg::REG_SCALE:     r_scale <= i_cfg_wdata;
                vvtp_pkg::REG_OFF_HORIZ: r_off_h <= i_cfg_wdata;
                vvtp_pkg::REG_OFF_VERT:  r_off_v <= i_cfg_wdata;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // coefficient path: free running; a written angle passes the ROM registers
    // and then r_coef, which is before the first item reaches the multipliers
    // ------------------------------------------------------------------
    vvtp_pkg::t_trig r_sth, r_cth, r_sph, r_cph;
    vvtp_pkg::t_coef r_coef;

    always_ff @(posedge i_clk) begin
        {r_sth, r_cth} <= TRIG_ROM[r_az];
        {r_sph, r_cph} <= TRIG_ROM[r_el];
        r_coef.v11 <= -r_sth;
        r_coef.v21 <= r_cth;
        r_coef.v12 <= -rnd_mul(r_cph, r_cth);
        r_coef.v22 <= -rnd_mul(r_cph, r_sth);
        r_coef.v13 <= -rnd_mul(r_sph, r_cth);
        r_coef.v23 <= -rnd_mul(r_sph, r_sth);
        r_coef.v32 <= r_sph;
        r_coef.v33 <= -r_cph;
    end

    // ------------------------------------------------------------------
    // item pipeline, all stages advance together on en
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic en;
    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && en;

    logic [6:0] r_v;   // stages s0..s6 (s6 is divider entry)

    // s0: input capture
    logic signed [CW-1:0] r_s0_x, r_s0_y, r_s0_z;
    logic                 r_s0_last;
    // s1: deltas
    logic signed [vvtp_pkg::DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic                                r_s1_last;
    // s2: products
    logic signed [vvtp_pkg::PROD_W-1:0] r_m11, r_m21, r_m12, r_m22, r_m32, r_m13, r_m23, r_m33;
    logic                               r_s2_last;
    // s3: sums
    logic signed [vvtp_pkg::SUM_W-1:0] r_sx, r_sy, r_sz;
    logic                              r_s3_last;
    // s4: eye coordinates
    logic signed [EW-1:0] r_xe, r_ye, r_ze;
    logic                 r_s4_last;
    // s5: numerators
    logic signed [MW-1:0] r_px, r_py;
    logic signed [EW-1:0] r_s5_ze;
    logic                 r_s5_last;

    logic signed [vvtp_pkg::SUM_W-1:0] n_tx, n_ty, n_tz;
    logic signed [MW-1:0]              n_scale_s;

    always_comb begin
        n_tx      = r_sx + RND_HALF;
        n_ty      = r_sy + RND_HALF;
        n_tz      = r_sz + RND_HALF;
        n_scale_s = MW'($signed({1'b0, r_scale}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], s_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x    <= i_s_axis_tdata[CW-1:0];
            r_s0_y    <= i_s_axis_tdata[2*CW-1:CW];
            r_s0_z    <= i_s_axis_tdata[3*CW-1:2*CW];
            r_s0_last <= i_s_axis_tlast;

            r_dx      <= {r_s0_x[CW-1], r_s0_x} - {r_piv_x[CW-1], r_piv_x};
            r_dy      <= {r_s0_y[CW-1], r_s0_y} - {r_piv_y[CW-1], r_piv_y};
            r_dz      <= {r_s0_z[CW-1], r_s0_z} - {r_piv_z[CW-1], r_piv_z};
            r_s1_last <= r_s0_last;

            r_m11     <= r_coef.v11 * r_dx;
            r_m21     <= r_coef.v21 * r_dy;
            r_m12     <= r_coef.v12 * r_dx;
            r_m22     <= r_coef.v22 * r_dy;
            r_m32     <= r_coef.v32 * r_dz;
            r_m13     <= r_coef.v13 * r_dx;
            r_m23     <= r_coef.v23 * r_dy;
            r_m33     <= r_coef.v33 * r_dz;
            r_s2_last <= r_s1_last;

            r_sx      <= vvtp_pkg::SUM_W'(r_m11) + vvtp_pkg::SUM_W'(r_m21);
            r_sy      <= vvtp_pkg::SUM_W'(r_m12) + vvtp_pkg::SUM_W'(r_m22)
                         + vvtp_pkg::SUM_W'(r_m32);
            r_sz      <= vvtp_pkg::SUM_W'(r_m13) + vvtp_pkg::SUM_W'(r_m23)
                         + vvtp_pkg::SUM_W'(r_m33);
            r_s3_last <= r_s2_last;

            r_xe      <= EW'(n_tx >>> 16) + EW'(r_piv_x);
            r_ye      <= EW'(n_ty >>> 16) + EW'(r_piv_y);
            r_ze      <= EW'(n_tz >>> 16) + EW'(r_piv_z) + vvtp_pkg::VIEW_OFS;
            r_s4_last <= r_s3_last;

            r_px      <= MW'(r_xe) * n_scale_s;
            r_py      <= MW'(r_ye) * n_scale_s;
            r_s5_ze   <= r_ze;
            r_s5_last <= r_s4_last;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage, x and y share ze
    // ------------------------------------------------------------------
    logic [NW-1:0]        r_nx [0:NW];
    logic [NW-1:0]        r_ny [0:NW];
    logic [ZW-1:0]        r_rx [0:NW];
    logic [ZW-1:0]        r_ry [0:NW];
    logic [NW-1:0]        r_qx [0:NW];
    logic [NW-1:0]        r_qy [0:NW];
    logic signed [EW-1:0] r_dze [0:NW];
    logic                 r_dsx [0:NW];
    logic                 r_dsy [0:NW];
    logic                 r_dlast [0:NW];
    logic [NW:1]          r_dv;

    logic [MW-1:0] n_ax, n_ay;
    always_comb begin
        n_ax = r_px[MW-1] ? MW'(-r_px) : MW'(r_px);
        n_ay = r_py[MW-1] ? MW'(-r_py) : MW'(r_py);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx[0]    <= n_ax[NW-1:0];
            r_ny[0]    <= n_ay[NW-1:0];
            r_rx[0]    <= '0;
            r_ry[0]    <= '0;
            r_qx[0]    <= '0;
            r_qy[0]    <= '0;
            r_dze[0]   <= r_s5_ze;
            r_dsx[0]   <= r_px[MW-1];
            r_dsy[0]   <= r_py[MW-1];
            r_dlast[0] <= r_s5_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[NW-1:1], r_v[6]};
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_div
        logic [ZW:0] trial_x, trial_y, dd;
        logic        ge_x, ge_y;

        always_comb begin
            dd      = {1'b0, r_dze[i][ZW-1:0]};
            trial_x = {r_rx[i], r_nx[i][NW-1]};
            trial_y = {r_ry[i], r_ny[i][NW-1]};
            ge_x    = trial_x >= dd;
            ge_y    = trial_y >= dd;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nx[i+1]    <= r_nx[i] << 1;
                r_ny[i+1]    <= r_ny[i] << 1;
                r_rx[i+1]    <= ge_x ? ZW'(trial_x - dd) : ZW'(trial_x);
                r_ry[i+1]    <= ge_y ? ZW'(trial_y - dd) : ZW'(trial_y);
                r_qx[i+1]    <= {r_qx[i][NW-2:0], ge_x};
                r_qy[i+1]    <= {r_qy[i][NW-2:0], ge_y};
                r_dze[i+1]   <= r_dze[i];
                r_dsx[i+1]   <= r_dsx[i];
                r_dsy[i+1]   <= r_dsy[i];
                r_dlast[i+1] <= r_dlast[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // finish: signed quotient, offset, truncate and saturate
    // ------------------------------------------------------------------
    logic                 r_f1_v, r_f2_v;
    logic signed [NW:0]   r_qsx, r_qsy;
    logic signed [FW-1:0] r_fx, r_fy;
    logic signed [EW-1:0] r_f1_ze, r_f2_ze;
    logic                 r_f1_last, r_f2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= r_dv[NW];
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qsx     <= r_dsx[NW] ? -$signed({1'b0, r_qx[NW]}) : $signed({1'b0, r_qx[NW]});
            r_qsy     <= r_dsy[NW] ? -$signed({1'b0, r_qy[NW]}) : $signed({1'b0, r_qy[NW]});
            r_f1_ze   <= r_dze[NW];
            r_f1_last <= r_dlast[NW];

            r_fx      <= FW'(r_qsx) + FW'($signed({r_off_h, 8'h00}));
            r_fy      <= FW'(r_qsy) + FW'($signed({r_off_v, 8'h00}));
            r_f2_ze   <= r_f1_ze;
            r_f2_last <= r_f1_last;
        end
    end

    logic        n_vis;
    logic [63:0] n_data;
    always_comb begin
        n_vis  = r_f2_ze > 0;
        n_data = '0;
        if (n_vis) begin
            n_data = {vvtp_pkg::DEPTH_W'(r_f2_ze), to_pixel(r_fy), to_pixel(r_fx)};
        end
    end

    // ------------------------------------------------------------------
    // output register plus skid entry
    // ------------------------------------------------------------------
    logic        r_out_v;
    logic [63:0] r_out_data, r_skid_data;
    logic        r_out_vis, r_out_last, r_skid_vis, r_skid_last;
    logic        push, pop;

    assign push = en && r_f2_v;
    assign pop  = r_out_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out_data <= r_skid_data;
                r_out_vis  <= r_skid_vis;
                r_out_last <= r_skid_last;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skid_data <= n_data;
                r_skid_vis  <= n_vis;
                r_skid_last <= r_f2_last;
            end else begin
                r_out_data <= n_data;
                r_out_vis  <= n_vis;
                r_out_last <= r_f2_last;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_vis;
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without output entry");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 64'd0))
        else $error("invisible vertex with nonzero payload");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[0])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> (r_skid_v && $stable(r_f2_v)))
        else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// ===== tb/tb_vertex_view_transform_project.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_view_transform_project
// Streams vertices through the view transform and projection block. Every
// accepted vertex is run through a local fixed-point projector. Each output
// item is checked field by field, in order, against the projected result.
// ----------------------------------------------------------------------------
module tb_vertex_view_transform_project;

    localparam int N_RANDOM  = 1250;
    localparam int LATENCY   = 68;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [31:0] depth;
        logic               vis;
        logic               last;
    } t_vertex_proj;

    // projector settings, mirror of the block registers
    int unsigned     az, el, scale;
    longint          piv_x, piv_y, piv_z, off_h, off_v;

    function automatic longint rnd_half(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // sine and cosine of an angle step in Q1.16 (Taylor series at Q30)
    function automatic void sin_cos_q16(int unsigned k, output longint sn,
                                        output longint cs);
        longint unsigned t, r, x, x2, st, ct;
        longint ssum, csum, s16, c16;
        int quad;
        t = (longint'(k) << 32) / 64'(360);
        quad = int'((t >> 30) & 3);
        r = t & (vvtp_pkg::ONE_Q30 - 1);
        x = (r * vvtp_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        st = x;
        ct = vvtp_pkg::ONE_Q30;
        ssum = longint'(x);
        csum = longint'(vvtp_pkg::ONE_Q30);
        for (int n = 1; n <= 8; n++) begin
            st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                ssum -= longint'(st);
                csum -= longint'(ct);
            end else begin
                ssum += longint'(st);
                csum += longint'(ct);
            end
        end
        ssum = clip(ssum, 0, longint'(vvtp_pkg::ONE_Q30));
        csum = clip(csum, 0, longint'(vvtp_pkg::ONE_Q30));
        s16 = (ssum + 8192) >>> 14;
        c16 = (csum + 8192) >>> 14;
        case (quad)
            0: begin sn = s16;  cs = c16;  end
            1: begin sn = c16;  cs = -s16; end
            2: begin sn = -s16; cs = -c16; end
            default: begin sn = -c16; cs = s16; end
        endcase
    endfunction

    function automatic longint to_pixel(longint e, longint ze, longint off);
        longint q;
        q = (e * longint'(scale)) / ze;   // SV division truncates toward zero
        return clip((q + off * 256) / 65536, -32768, 32767);
    endfunction

    function automatic t_vertex_proj project_vertex(logic [71:0] d, logic last);
        t_vertex_proj r;
        longint sth, cth, sph, cph, dx, dy, dz, xe, ye, ze;
        longint v12, v22, v13, v23;
        dx = longint'($signed(d[23:0])) - piv_x;
        dy = longint'($signed(d[47:24])) - piv_y;
        dz = longint'($signed(d[71:48])) - piv_z;
        sin_cos_q16(az % 360, sth, cth);
        sin_cos_q16(el % 360, sph, cph);
        v12 = -rnd_half(cph * cth, 16);
        v22 = -rnd_half(cph * sth, 16);
        v13 = -rnd_half(sph * cth, 16);
        v23 = -rnd_half(sph * sth, 16);
        xe = rnd_half(-sth * dx + cth * dy, 16) + piv_x;
        ye = rnd_half(v12 * dx + v22 * dy + sph * dz, 16) + piv_y;
        ze = rnd_half(v13 * dx + v23 * dy - cph * dz, 16)
             + longint'(vvtp_pkg::VIEW_DISTANCE) * 256 + piv_z;
        ze = clip(ze, -64'sd2147483648, 64'sd2147483647);
        r.last = last;
        if (ze <= 0) begin
            r.px = '0; r.py = '0; r.depth = '0; r.vis = 1'b0;
        end else begin
            r.px = 16'(to_pixel(xe, ze, off_h));
            r.py = 16'(to_pixel(ye, ze, off_v));
            r.depth = 32'(ze);
            r.vis = 1'b1;
        end
        return r;
    endfunction

    int n_errors = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    class ProjectionScoreboard;
        t_vertex_proj pending[$];

        function void note_vertex(logic [71:0] d, logic last);
            pending.push_back(project_vertex(d, last));
        endfunction

        task check_pixel(logic [63:0] d, logic vis, logic last);
            t_vertex_proj w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
                return;
            end
            w = pending.pop_front();
            if ($signed(d[15:0]) != w.px) report_mismatch("pixel_x", $signed(d[15:0]), w.px);
            if ($signed(d[31:16]) != w.py)
                report_mismatch("pixel_y", $signed(d[31:16]), w.py);
            if ($signed(d[63:32]) != w.depth)
                report_mismatch("eye_depth", $signed(d[63:32]), w.depth);
            if (vis != w.vis) report_mismatch("visible", vis, w.vis);
            if (last != w.last) report_mismatch("batch_done", last, w.last);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [63:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;

    vertex_view_transform_project u_dut (.*);

    always #5 i_clk = ~i_clk;

    ProjectionScoreboard sb = new();
    int send_idle_pct = 0, recv_idle_pct = 0;
    int wdog = 0;

    // output side: random stall, check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pixel(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end
    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            wdog = 0;
        else if (i_rst_n)
            wdog++;
        if (wdog >= WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            vvtp_pkg::REG_AZIMUTH:   az = val[8:0];
            vvtp_pkg::REG_ELEVATION: el = val[8:0];
            vvtp_pkg::REG_PIVOT_X:   piv_x = $signed(val[23:0]);
            vvtp_pkg::REG_PIVOT_Y:   piv_y = $signed(val[23:0]);
            vvtp_pkg::REG_PIVOT_Z:   piv_z = $signed(val[23:0]);
            vvtp_pkg::REG_SCALE:     scale = val;
            vvtp_pkg::REG_OFF_HORIZ: off_h = $signed(val);
            vvtp_pkg::REG_OFF_VERT:  off_v = $signed(val);
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_vertex(logic [71:0] d, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_vertex(d, last);
        @(negedge i_clk);
    endtask

    // called at a falling edge; drops valid before the next rising edge
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom_range(4095) - 2048);
            1: return 24'($urandom_range(1000000) - 500000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic write_random_setting();
        write_reg(vvtp_pkg::REG_AZIMUTH, $urandom_range(511));
        write_reg(vvtp_pkg::REG_ELEVATION, $urandom_range(511));
        write_reg(vvtp_pkg::REG_PIVOT_X,
                  $urandom_range(1) ? 32'($urandom_range(8191) - 4096) : $urandom);
        write_reg(vvtp_pkg::REG_PIVOT_Y,
                  $urandom_range(1) ? 32'($urandom_range(8191) - 4096) : $urandom);
        write_reg(vvtp_pkg::REG_PIVOT_Z,
                  $urandom_range(1) ? 32'($urandom_range(8191) - 4096) : $urandom);
        write_reg(vvtp_pkg::REG_SCALE,
                  $urandom_range(1) ? 32'($urandom_range(1 << 20)) : $urandom);
        write_reg(vvtp_pkg::REG_OFF_HORIZ,
                  $urandom_range(1) ? 32'($urandom_range(65535) - 32768) : $urandom);
        write_reg(vvtp_pkg::REG_OFF_VERT,
                  $urandom_range(1) ? 32'($urandom_range(65535) - 32768) : $urandom);
    endtask

    initial begin
        logic [23:0] ext[4];
        az = 0; el = 0; piv_x = 0; piv_y = 0; piv_z = 0;
        scale = 32'h0001_0000; off_h = 0; off_v = 0;
        ext = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes at reset setting, then depth at, below and above zero
        for (int i = 0; i < 4; i++)
            send_vertex({ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]}, i[0]);
        send_vertex({24'(3000 * 256), 24'd0, 24'd0}, 1'b0);
        send_vertex({24'(3000 * 256) + 24'd1, 24'd100, 24'd100}, 1'b1);
        send_vertex({24'(3000 * 256) - 24'd1, 24'h7FFFFF, 24'h800000}, 1'b0);
        drain();
        // extreme settings: azimuth beyond range, elevation 359, max scale, max and min offsets
        write_reg(vvtp_pkg::REG_AZIMUTH, 9'd511);
        write_reg(vvtp_pkg::REG_ELEVATION, 9'd359);
        write_reg(vvtp_pkg::REG_PIVOT_X, 32'h00800000);
        write_reg(vvtp_pkg::REG_PIVOT_Y, 32'h007FFFFF);
        write_reg(vvtp_pkg::REG_PIVOT_Z, 32'h00800000);
        write_reg(vvtp_pkg::REG_SCALE, 32'hFFFFFFFF);
        write_reg(vvtp_pkg::REG_OFF_HORIZ, 32'h7FFFFFFF);
        write_reg(vvtp_pkg::REG_OFF_VERT, 32'h80000000);
        for (int i = 0; i < 8; i++)
            send_vertex({ext[i % 4], ext[(i + 3) % 4], ext[(i / 2) % 4]}, i[0]);
        drain();
        write_reg(vvtp_pkg::REG_AZIMUTH, 9'd90);
        write_reg(vvtp_pkg::REG_ELEVATION, 9'd45);
        write_reg(vvtp_pkg::REG_SCALE, 32'd0);
        write_reg(vvtp_pkg::REG_OFF_HORIZ, 32'h80000000);
        write_reg(vvtp_pkg::REG_OFF_VERT, 32'h7FFFFFFF);
        for (int i = 0; i < 6; i++)
            send_vertex({rand_coord(), ext[i % 4], rand_coord()}, i[0]);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 17 : (phase == 1 ? 55 : 0);
            recv_idle_pct = phase == 0 ? 55 : (phase == 1 ? 17 : 0);
            for (int s = 0; s < 5; s++) begin
                write_random_setting();
                for (int i = 0; i < N_RANDOM / 15; i++)
                    send_vertex({rand_coord(), rand_coord(), rand_coord()},
                                $urandom_range(7) == 0);
                drain();
            end
        end

        if (n_errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
